// File: sv/wf2q_pkg.sv
// Shared types and constants of the WF2Q+ packet scheduler.
// Depends on nothing; every other file imports it.
package wf2q_pkg;

   localparam int NUM_FLOWS_DEF  = 256;
   localparam int SLOTS_DEF      = 16;
   localparam int TAG_WIDTH_DEF  = 48;

   localparam int FLOW_W   = 8;
   localparam int SIZE_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int BYTES_W  = 24;
   localparam int WSUM_W   = 24;
   localparam int DVD_W    = 40;
   localparam int DVS_W    = 24;
   localparam int FRAC_SH  = 24;

   localparam logic [BYTES_W-1:0] DEFAULT_LIMIT = 24'd10000;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_SET  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RES_ENQUEUED      = 3'd0,
      RES_OVER_LIMIT    = 3'd1,
      RES_FIFO_FULL     = 3'd2,
      RES_ZERO_WEIGHT   = 3'd3,
      RES_SERVED        = 3'd4,
      RES_NONE_ELIGIBLE = 3'd5,
      RES_WRITTEN       = 3'd6
   } res_type;

   typedef enum logic [1:0] {
      DIV_ENQ  = 2'd0,
      DIV_NEXT = 2'd1,
      DIV_VT   = 2'd2
   } div_src_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ENQ_RD, S_ENQ_LD, S_ENQ_CHK, S_ENQ_DIV, S_ENQ_FIN,
      S_ENQ_WR_E, S_ENQ_SCAN, S_ENQ_V, S_ENQ_WR, S_SET_RD, S_SET_LD, S_SET,
      S_SET_WR, S_DQ_INIT, S_DQ_SCAN, S_DQ_RD, S_DQ_LD, S_DQ_PKT, S_DQ_POP,
      S_DQ_NXT, S_DQ_NXT2, S_DQ_DIV, S_DQ_FIN, S_DQ_WR, S_DQ_MSCAN, S_DQ_VDIV,
      S_DQ_VWAIT, S_DQ_V, S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic        accept;
      logic        clear;
      logic        load_cur;
      logic        enq_commit;
      logic        rec_write;
      logic        scan_init;
      logic        scan_run;
      logic        scan_best;
      logic        sel_best;
      logic        pop;
      logic        start_adv;
      logic        fin_update;
      logic        set_apply;
      logic        div_start;
      div_src_type div_src;
      logic        v_raise;
      logic        v_adv;
      logic        set_status;
      res_type     status;
      logic        serve;
      logic        res_load;
   } dp_cmd_type;

   typedef struct packed {
      logic    clr_done;
      logic    scan_done;
      logic    found;
      logic    div_busy;
      logic    enq_ok;
      logic    cur_empty;
      logic    pop_left;
      logic    in_range;
      logic    out_free;
      res_type drop_code;
   } dp_stat_type;

endpackage

// File: sv/wf2q_if.sv
// Valid/ready channel interfaces for the scheduler's request and response.
// Depends on wf2q_pkg for the field widths.
interface wf2q_req_if import wf2q_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [FLOW_W-1:0]   flow;
   logic [SIZE_W-1:0]   pkt_size;
   logic [WEIGHT_W-1:0] weight;
   logic [BYTES_W-1:0]  queue_limit;

   modport source (output valid, op, flow, pkt_size, weight, queue_limit, input ready);
   modport sink (input valid, op, flow, pkt_size, weight, queue_limit, output ready);
endinterface

interface wf2q_rsp_if import wf2q_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [FLOW_W-1:0] served_flow;
   logic [SIZE_W-1:0] served_size;

   modport source (output valid, status, served_flow, served_size, input ready);
   modport sink (input valid, status, served_flow, served_size, output ready);
endinterface

// File: sv/wf2q_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wf2q_pkg for operand widths.
module wf2q_div import wf2q_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);
   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// File: sv/wf2q_dp.sv
// Datapath of the scheduler: per-flow memories, packet size store, scan unit,
// tag arithmetic and response register. Depends on wf2q_pkg and wf2q_div.
module wf2q_dp import wf2q_pkg::*; #(
   parameter int NUM_FLOWS      = NUM_FLOWS_DEF,
   parameter int SLOTS_PER_FLOW = SLOTS_DEF,
   parameter int TAG_WIDTH      = TAG_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [FLOW_W-1:0]   req_flow,
   input  logic [SIZE_W-1:0]   req_pkt_size,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [BYTES_W-1:0]  req_queue_limit,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [FLOW_W-1:0]   rsp_served_flow,
   output logic [SIZE_W-1:0]   rsp_served_size,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat
);
   localparam int FW   = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
   localparam int CNTW = $clog2(NUM_FLOWS + 1);
   localparam int HW   = (SLOTS_PER_FLOW > 1) ? $clog2(SLOTS_PER_FLOW) : 1;
   localparam int CW   = $clog2(SLOTS_PER_FLOW + 1);
   localparam int SAW  = (NUM_FLOWS * SLOTS_PER_FLOW > 1) ?
                         $clog2(NUM_FLOWS * SLOTS_PER_FLOW) : 1;
   localparam int FEW  = ((FW > FLOW_W) ? FW : FLOW_W) + 1;
   localparam int SUMW = CW + 1;

   function automatic logic [TAG_WIDTH-1:0] sat_add(input logic [TAG_WIDTH-1:0] a,
                                                     input logic [TAG_WIDTH-1:0] b);
      logic [TAG_WIDTH:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         return s[TAG_WIDTH] ? {TAG_WIDTH{1'b1}} : s[TAG_WIDTH-1:0];
      end
   endfunction

   logic [TAG_WIDTH-1:0] start_mem  [NUM_FLOWS];
   logic [TAG_WIDTH-1:0] finish_mem [NUM_FLOWS];
   logic [BYTES_W-1:0]   qb_mem     [NUM_FLOWS];
   logic [WEIGHT_W-1:0]  wt_mem     [NUM_FLOWS];
   logic [BYTES_W-1:0]   lim_mem    [NUM_FLOWS];
   logic [HW-1:0]        head_mem   [NUM_FLOWS];
   logic [CW-1:0]        cnt_mem    [NUM_FLOWS];
   logic [SIZE_W-1:0]    size_mem   [NUM_FLOWS * SLOTS_PER_FLOW];

   logic [TAG_WIDTH-1:0] rd_start_ff, rd_fin_ff;
   logic [BYTES_W-1:0]   rd_q_ff, rd_lim_ff;
   logic [WEIGHT_W-1:0]  rd_w_ff;
   logic [HW-1:0]        rd_head_ff;
   logic [CW-1:0]        rd_cnt_ff;
   logic [SIZE_W-1:0]    size_rd_ff;

   logic [TAG_WIDTH-1:0] cur_start_ff, cur_fin_ff;
   logic [BYTES_W-1:0]   cur_q_ff, cur_lim_ff;
   logic [WEIGHT_W-1:0]  cur_w_ff;
   logic [HW-1:0]        cur_head_ff;
   logic [CW-1:0]        cur_cnt_ff;
   logic [FW-1:0]        cur_flow_ff;
   logic [SIZE_W-1:0]    size_ff, pkt_ff;
   logic [WEIGHT_W-1:0]  w_ff;
   logic [BYTES_W-1:0]   lim_ff;
   logic                 in_range_ff;

   logic [CNTW-1:0]      scan_cnt_ff;
   logic                 eval_v_ff;
   logic [FW-1:0]        eval_idx_ff;
   logic                 found_ff;
   logic [FW-1:0]        best_ff;
   logic [TAG_WIDTH-1:0] best_fin_ff, min_ff;

   logic [TAG_WIDTH-1:0] v_ff;
   logic [WSUM_W-1:0]    wsum_ff;
   logic                 div_zero_ff;

   res_type              pend_status_ff, rsp_status_ff;
   logic                 pend_serve_ff;
   logic                 rsp_valid_ff;
   logic [FLOW_W-1:0]    rsp_flow_ff;
   logic [SIZE_W-1:0]    rsp_size_ff;

   logic [FEW-1:0]       flow_ext;
   logic                 scan_issue;
   logic [FW-1:0]        raddr, waddr;
   logic                 mem_we;
   logic [SAW-1:0]       base_addr, sa_w, sa_r;
   logic [SUMW-1:0]      slot_sum;
   logic [HW-1:0]        slot;
   logic [HW:0]          head_inc;
   logic [HW-1:0]        head_next;
   logic [BYTES_W:0]     q_plus;
   logic                 over, full, zero_w;
   logic [SIZE_W-1:0]    dvd_src;
   logic [DVS_W-1:0]     dvs_src;
   logic                 div_busy;
   logic [DVD_W-1:0]     quotient;
   logic [TAG_WIDTH-1:0] tag_max, inc, adv, vmax;
   logic                 rd_live;

   assign tag_max  = {TAG_WIDTH{1'b1}};
   assign flow_ext = FEW'(req_flow);

   assign scan_issue = cmd.scan_run && (scan_cnt_ff < CNTW'(NUM_FLOWS));
   assign raddr      = scan_issue ? scan_cnt_ff[FW-1:0] : cur_flow_ff;
   assign waddr      = cmd.clear ? scan_cnt_ff[FW-1:0] : cur_flow_ff;
   assign mem_we     = cmd.clear || cmd.rec_write;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[waddr]  <= cmd.clear ? '0 : cur_start_ff;
         finish_mem[waddr] <= cmd.clear ? '0 : cur_fin_ff;
         qb_mem[waddr]     <= cmd.clear ? '0 : cur_q_ff;
         wt_mem[waddr]     <= cmd.clear ? '0 : cur_w_ff;
         lim_mem[waddr]    <= cmd.clear ? DEFAULT_LIMIT : cur_lim_ff;
         head_mem[waddr]   <= cmd.clear ? '0 : cur_head_ff;
         cnt_mem[waddr]    <= cmd.clear ? '0 : cur_cnt_ff;
      end
      rd_start_ff <= start_mem[raddr];
      rd_fin_ff   <= finish_mem[raddr];
      rd_q_ff     <= qb_mem[raddr];
      rd_w_ff     <= wt_mem[raddr];
      rd_lim_ff   <= lim_mem[raddr];
      rd_head_ff  <= head_mem[raddr];
      rd_cnt_ff   <= cnt_mem[raddr];
   end

   assign base_addr = SAW'(SAW'(cur_flow_ff) * SAW'(SLOTS_PER_FLOW));
   assign slot_sum  = SUMW'(cur_head_ff) + SUMW'(cur_cnt_ff);
   assign slot      = (slot_sum >= SUMW'(SLOTS_PER_FLOW)) ?
                      HW'(slot_sum - SUMW'(SLOTS_PER_FLOW)) : HW'(slot_sum);
   assign sa_w      = base_addr + SAW'(slot);
   assign sa_r      = base_addr + SAW'(cur_head_ff);
   assign head_inc  = {1'b0, cur_head_ff} + 1'b1;
   assign head_next = (head_inc >= (HW + 1)'(SLOTS_PER_FLOW)) ? '0 : head_inc[HW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.enq_commit) begin
         size_mem[sa_w] <= size_ff;
      end
      size_rd_ff <= size_mem[sa_r];
   end

   assign q_plus = {1'b0, cur_q_ff} + (BYTES_W + 1)'(size_ff);
   assign over   = q_plus > {1'b0, cur_lim_ff};
   assign full   = cur_cnt_ff >= CW'(SLOTS_PER_FLOW);
   assign zero_w = cur_w_ff == '0;

   always_comb begin
      dvd_src = size_ff;
      dvs_src = DVS_W'(cur_w_ff);
      case (cmd.div_src)
         DIV_ENQ: begin
            dvd_src = size_ff;
            dvs_src = DVS_W'(cur_w_ff);
         end
         DIV_NEXT: begin
            dvd_src = size_rd_ff;
            dvs_src = DVS_W'(cur_w_ff);
         end
         DIV_VT: begin
            dvd_src = pkt_ff;
            dvs_src = wsum_ff;
         end
         default: begin
            dvd_src = size_ff;
            dvs_src = DVS_W'(cur_w_ff);
         end
      endcase
   end

   wf2q_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({dvd_src, {FRAC_SH{1'b0}}}),
      .divisor  (dvs_src),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign inc  = (div_zero_ff || (64'(quotient) > 64'(tag_max))) ?
                 tag_max : TAG_WIDTH'(quotient);
   assign adv  = sat_add(v_ff, inc);
   assign vmax = (v_ff > cur_fin_ff) ? v_ff : cur_fin_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_zero_ff <= dvs_src == '0;
      end
      if (cmd.accept) begin
         cur_flow_ff <= flow_ext[FW-1:0];
         size_ff     <= req_pkt_size;
         w_ff        <= req_weight;
         lim_ff      <= req_queue_limit;
         in_range_ff <= flow_ext < FEW'(NUM_FLOWS);
      end
      if (cmd.sel_best) begin
         cur_flow_ff <= best_ff;
      end
      if (cmd.load_cur) begin
         cur_start_ff <= rd_start_ff;
         cur_fin_ff   <= rd_fin_ff;
         cur_q_ff     <= rd_q_ff;
         cur_w_ff     <= rd_w_ff;
         cur_lim_ff   <= rd_lim_ff;
         cur_head_ff  <= rd_head_ff;
         cur_cnt_ff   <= rd_cnt_ff;
      end
      if (cmd.enq_commit) begin
         cur_cnt_ff <= cur_cnt_ff + 1'b1;
         cur_q_ff   <= q_plus[BYTES_W-1:0];
         if (cur_cnt_ff == '0) begin
            cur_start_ff <= vmax;
         end
      end
      if (cmd.pop) begin
         pkt_ff      <= size_rd_ff;
         cur_head_ff <= head_next;
         cur_cnt_ff  <= cur_cnt_ff - 1'b1;
         cur_q_ff    <= cur_q_ff - BYTES_W'(size_rd_ff);
      end
      if (cmd.start_adv) begin
         cur_start_ff <= cur_fin_ff;
      end
      if (cmd.fin_update) begin
         cur_fin_ff <= sat_add(cur_start_ff, inc);
      end
      if (cmd.set_apply) begin
         cur_w_ff   <= w_ff;
         cur_lim_ff <= lim_ff;
      end
   end

   assign rd_live = rd_cnt_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         eval_v_ff   <= 1'b0;
         found_ff    <= 1'b0;
      end else if (cmd.scan_init) begin
         scan_cnt_ff <= '0;
         eval_v_ff   <= 1'b0;
         found_ff    <= 1'b0;
      end else if (cmd.clear) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end else begin
         eval_v_ff <= scan_issue;
         if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (eval_v_ff && cmd.scan_best && rd_live && (rd_start_ff <= v_ff) &&
             (!found_ff || (rd_fin_ff < best_fin_ff))) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= scan_cnt_ff[FW-1:0];
      if (cmd.scan_init) begin
         min_ff <= cur_start_ff;
      end else if (eval_v_ff && rd_live) begin
         if (!cmd.scan_best && (rd_start_ff < min_ff)) begin
            min_ff <= rd_start_ff;
         end
         if (cmd.scan_best && (rd_start_ff <= v_ff) &&
             (!found_ff || (rd_fin_ff < best_fin_ff))) begin
            best_ff     <= eval_idx_ff;
            best_fin_ff <= rd_fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         wsum_ff <= '0;
      end else begin
         if (cmd.v_raise && (min_ff > v_ff)) begin
            v_ff <= min_ff;
         end
         if (cmd.v_adv) begin
            v_ff <= (min_ff > adv) ? min_ff : adv;
         end
         if (cmd.set_apply) begin
            wsum_ff <= wsum_ff - WSUM_W'(cur_w_ff) + WSUM_W'(w_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         pend_status_ff <= cmd.status;
         pend_serve_ff  <= cmd.serve;
      end
      if (cmd.res_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_flow_ff   <= pend_serve_ff ? FLOW_W'(cur_flow_ff) : '0;
         rsp_size_ff   <= pend_serve_ff ? pkt_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat           = '0;
      stat.clr_done  = scan_cnt_ff == CNTW'(NUM_FLOWS - 1);
      stat.scan_done = (scan_cnt_ff == CNTW'(NUM_FLOWS)) && !eval_v_ff;
      stat.found     = found_ff;
      stat.div_busy  = div_busy;
      stat.enq_ok    = in_range_ff && !over && !full && !zero_w;
      stat.cur_empty = cur_cnt_ff == '0;
      stat.pop_left  = cur_cnt_ff > CW'(1);
      stat.in_range  = in_range_ff;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
      if (!in_range_ff) begin
         stat.drop_code = RES_ZERO_WEIGHT;
      end else if (over) begin
         stat.drop_code = RES_OVER_LIMIT;
      end else if (full) begin
         stat.drop_code = RES_FIFO_FULL;
      end else begin
         stat.drop_code = RES_ZERO_WEIGHT;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_served_flow = rsp_flow_ff;
   assign rsp_served_size = rsp_size_ff;
endmodule

// File: sv/wf2q_ctrl.sv
// Controller state machine of the scheduler; sequences the datapath.
// Depends on wf2q_pkg for the state, command and status types.
module wf2q_ctrl import wf2q_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_op,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);
   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (stat.clr_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_ENQ:  state_in = S_ENQ_RD;
                  OP_DEQ:  state_in = S_DQ_INIT;
                  OP_SET:  state_in = S_SET_RD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ENQ_RD: state_in = S_ENQ_LD;
         S_ENQ_LD: state_in = S_ENQ_CHK;
         S_ENQ_CHK: begin
            if (!stat.enq_ok) state_in = S_DONE;
            else if (stat.cur_empty) state_in = S_ENQ_DIV;
            else state_in = S_ENQ_WR;
         end
         S_ENQ_DIV: if (!stat.div_busy) state_in = S_ENQ_FIN;
         S_ENQ_FIN: state_in = S_ENQ_WR_E;
         S_ENQ_WR_E: state_in = S_ENQ_SCAN;
         S_ENQ_SCAN: if (stat.scan_done) state_in = S_ENQ_V;
         S_ENQ_V: state_in = S_DONE;
         S_ENQ_WR: state_in = S_DONE;
         S_SET_RD: state_in = S_SET_LD;
         S_SET_LD: state_in = S_SET;
         S_SET: state_in = stat.in_range ? S_SET_WR : S_DONE;
         S_SET_WR: state_in = S_DONE;
         S_DQ_INIT: state_in = S_DQ_SCAN;
         S_DQ_SCAN: begin
            if (stat.scan_done) state_in = stat.found ? S_DQ_RD : S_DONE;
         end
         S_DQ_RD: state_in = S_DQ_LD;
         S_DQ_LD: state_in = S_DQ_PKT;
         S_DQ_PKT: state_in = S_DQ_POP;
         S_DQ_POP: state_in = stat.pop_left ? S_DQ_NXT : S_DQ_WR;
         S_DQ_NXT: state_in = S_DQ_NXT2;
         S_DQ_NXT2: state_in = S_DQ_DIV;
         S_DQ_DIV: if (!stat.div_busy) state_in = S_DQ_FIN;
         S_DQ_FIN: state_in = S_DQ_WR;
         S_DQ_WR: state_in = S_DQ_MSCAN;
         S_DQ_MSCAN: if (stat.scan_done) state_in = S_DQ_VDIV;
         S_DQ_VDIV: state_in = S_DQ_VWAIT;
         S_DQ_VWAIT: if (!stat.div_busy) state_in = S_DQ_V;
         S_DQ_V: state_in = S_DONE;
         S_DONE: if (stat.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.clear = 1'b1;
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_ENQ_LD, S_SET_LD, S_DQ_LD: cmd.load_cur = 1'b1;
         S_ENQ_CHK: begin
            if (!stat.enq_ok) begin
               cmd.set_status = 1'b1;
               cmd.status     = stat.drop_code;
            end else begin
               cmd.enq_commit = 1'b1;
               cmd.div_start  = stat.cur_empty;
               cmd.div_src    = DIV_ENQ;
            end
         end
         S_ENQ_FIN, S_DQ_FIN: cmd.fin_update = 1'b1;
         S_ENQ_WR_E: begin
            cmd.rec_write = 1'b1;
            cmd.scan_init = 1'b1;
         end
         S_ENQ_SCAN, S_DQ_MSCAN: cmd.scan_run = 1'b1;
         S_ENQ_V: begin
            cmd.v_raise    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = RES_ENQUEUED;
         end
         S_ENQ_WR: begin
            cmd.rec_write  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = RES_ENQUEUED;
         end
         S_SET: begin
            cmd.set_apply  = stat.in_range;
            cmd.set_status = 1'b1;
            cmd.status     = RES_WRITTEN;
         end
         S_SET_WR: cmd.rec_write = 1'b1;
         S_DQ_INIT: cmd.scan_init = 1'b1;
         S_DQ_SCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_best = 1'b1;
            if (stat.scan_done) begin
               cmd.sel_best   = stat.found;
               cmd.set_status = !stat.found;
               cmd.status     = RES_NONE_ELIGIBLE;
            end
         end
         S_DQ_POP: cmd.pop = 1'b1;
         S_DQ_NXT2: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_NEXT;
            cmd.start_adv = 1'b1;
         end
         S_DQ_WR: begin
            cmd.rec_write = 1'b1;
            cmd.scan_init = 1'b1;
         end
         S_DQ_VDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_VT;
         end
         S_DQ_V: begin
            cmd.v_adv      = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = RES_SERVED;
            cmd.serve      = 1'b1;
         end
         S_DONE: cmd.res_load = stat.out_free;
         default: cmd = '0;
      endcase
   end
endmodule

// File: sv/wf2q_plus_packet_scheduler_top.sv
// Top level of the WF2Q+ packet scheduler: controller plus datapath.
// Depends on wf2q_pkg, wf2q_if, wf2q_ctrl and wf2q_dp.

// The scheduler takes one request at a time and returns one response for each
// enqueue, dequeue or set-flow request (op 3 is taken and answered with
// nothing). After reset a clearing pass initialises the per-flow memory,
// during which no request is taken. The per-flow memory has a single read
// port, which the minimum and eligibility scans walk one flow per cycle,
// and tag and virtual-time increments come from the bit-serial divider.
module wf2q_plus_packet_scheduler_top import wf2q_pkg::*; #(
   parameter int NUM_FLOWS      = NUM_FLOWS_DEF,
   parameter int SLOTS_PER_FLOW = SLOTS_DEF,
   parameter int TAG_WIDTH      = TAG_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   wf2q_req_if.sink    req_chan,
   wf2q_rsp_if.source  rsp_chan
);
   dp_cmd_type  cmd;
   dp_stat_type stat;

   wf2q_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wf2q_dp #(
      .NUM_FLOWS      (NUM_FLOWS),
      .SLOTS_PER_FLOW (SLOTS_PER_FLOW),
      .TAG_WIDTH      (TAG_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_flow        (req_chan.flow),
      .req_pkt_size    (req_chan.pkt_size),
      .req_weight      (req_chan.weight),
      .req_queue_limit (req_chan.queue_limit),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_served_flow (rsp_chan.served_flow),
      .rsp_served_size (rsp_chan.served_size),
      .cmd             (cmd),
      .stat            (stat)
   );

`ifndef SYNTHESIS
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !stat.div_busy)
      else $error("Divider busy while a request may be taken.");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_run |-> (!cmd.rec_write && !cmd.enq_commit))
      else $error("Flow record written during a scan.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.op != OP_NONE)) |=> !req_chan.ready)
      else $error("Second request taken before the first completed.");
`endif
endmodule
